>>> hw/rtl/cdte_pkg.sv
// Shared types, constants and the month offset table for the date to epoch converter.
package cdte_pkg;

  // Calendar limits; the year is clamped into this range
  localparam logic [11:0] YearFirst    = 12'd1970;
  localparam logic [11:0] YearLast     = 12'd2105;
  // The only century year in range that is not a leap year
  localparam logic [11:0] YearSkipLeap = 12'd2100;

  localparam logic [8:0]  DaysPerYear   = 9'd365;
  localparam logic [16:0] SecsPerDay    = 17'(24 * 60 * 60);
  localparam logic [11:0] SecsPerHour   = 12'd3600;
  localparam logic [5:0]  SecsPerMinute = 6'd60;
  localparam logic [19:0] UsecsPerSec   = 20'd1000000;

  localparam logic [3:0]  MonthFeb = 4'd2;

  typedef logic [15:0] days_t;
  typedef logic [16:0] tod_t;
  typedef logic [31:0] secs_t;
  typedef logic [51:0] usecs_t;

  // One request as it arrives on the date channel
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } date_t;

  // After the first stage: whole days since the epoch and seconds within the day
  typedef struct packed {
    days_t days;
    tod_t  tod;
  } day_sum_t;

  // Days before the first of each month in a common year; months past 12 act as December
  function automatic logic [8:0] month_offset(input logic [3:0] month);
    logic [8:0] off;
    case (month)
      4'd0, 4'd1: off = 9'd0;
      4'd2:       off = 9'(31);
      4'd3:       off = 9'(31 + 28);
      4'd4:       off = 9'(31 + 28 + 31);
      4'd5:       off = 9'(31 + 28 + 31 + 30);
      4'd6:       off = 9'(31 + 28 + 31 + 30 + 31);
      4'd7:       off = 9'(31 + 28 + 31 + 30 + 31 + 30);
      4'd8:       off = 9'(31 + 28 + 31 + 30 + 31 + 30 + 31);
      4'd9:       off = 9'(31 + 28 + 31 + 30 + 31 + 30 + 31 + 31);
      4'd10:      off = 9'(31 + 28 + 31 + 30 + 31 + 30 + 31 + 31 + 30);
      4'd11:      off = 9'(31 + 28 + 31 + 30 + 31 + 30 + 31 + 31 + 30 + 31);
      4'd12, 4'd13, 4'd14, 4'd15:
                  off = 9'(31 + 28 + 31 + 30 + 31 + 30 + 31 + 31 + 30 + 31 + 30);
      default:    off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> hw/rtl/cdte_date_if.sv
// Date channel: one calendar date and time of day per request.
interface cdte_date_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, year, month, day_of_month, hour, minute, second,
                  input ready);
  modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                  output ready);
endinterface

>>> hw/rtl/cdte_epoch_if.sv
// Epoch channel: seconds and microseconds since 1970-01-01 00:00:00 per request.
interface cdte_epoch_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic [51:0] epoch_microseconds;

  modport source (output valid, epoch_seconds, epoch_microseconds, input ready);
  modport sink   (input valid, epoch_seconds, epoch_microseconds, output ready);
endinterface

>>> hw/rtl/calendar_date_to_epoch_time.sv
// Calendar date and time to epoch seconds and microseconds, three-stage pipeline.
//
// Usage:
//   date  : valid/ready request channel carrying year (clamped to 1970..2105),
//           month, day_of_month, hour, minute and second.
//   epoch : valid/ready request channel carrying epoch_seconds (since
//           1970-01-01 00:00:00) and epoch_microseconds (seconds * 1000000).
//   Every date request produces exactly one epoch request, in order.
// Path: an accepted date passes through the three register stages (day count,
//   day-to-second scale, microsecond multiply) on its way to epoch.valid.
// Throughput: one request per cycle while epoch.ready stays high.
// Stalls: each stage holds its data while the next is full, and ready
//   ripples back, so up to three requests sit in the pipe while epoch.ready
//   is low; nothing is dropped or repeated.
// Reset: rst (synchronous, active high) clears the stage valid bits; the
//   pipe is empty and date.ready is high in the first cycle after reset.
module calendar_date_to_epoch_time (
  input  logic                clk,
  input  logic                rst,
  cdte_date_if.sink           date,
  cdte_epoch_if.source        epoch
);

  cdte_pkg::date_t    date_data;
  logic               v1;
  logic               r1;
  cdte_pkg::day_sum_t d1;
  logic               v2;
  logic               r2;
  cdte_pkg::secs_t    d2;
  logic               r3;

  // Collect the date fields
  assign date_data.year         = date.year;
  assign date_data.month        = date.month;
  assign date_data.day_of_month = date.day_of_month;
  assign date_data.hour         = date.hour;
  assign date_data.minute       = date.minute;
  assign date_data.second       = date.second;

  cdte_day_count u_day (
    .clk      (clk),
    .rst      (rst),
    .up_valid (date.valid),
    .up_ready (date.ready),
    .up_data  (date_data),
    .dn_valid (v1),
    .dn_ready (r1),
    .dn_data  (d1)
  );

  cdte_sec_scale u_sec (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v1),
    .up_ready (r1),
    .up_data  (d1),
    .dn_valid (v2),
    .dn_ready (r2),
    .dn_data  (d2)
  );

  cdte_usec_scale u_usec (
    .clk      (clk),
    .rst      (rst),
    .up_valid (v2),
    .up_ready (r2),
    .up_data  (d2),
    .dn_valid (epoch.valid),
    .dn_ready (r3),
    .dn_secs  (epoch.epoch_seconds),
    .dn_usecs (epoch.epoch_microseconds)
  );

  assign r3 = epoch.ready;

  // Checks
  logic       in_fire;
  logic       out_fire;
  logic [1:0] fill;

  assign in_fire  = date.valid && date.ready;
  assign out_fire = epoch.valid && epoch.ready;
  assign fill     = 2'($countones({v1, v2, epoch.valid}));

  // Pipe is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !v1 && !v2 && !epoch.valid)
    else $error("pipeline not empty after reset");

  // Occupancy tracks accepted minus delivered requests
  a_fill_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> 3'(fill) == 3'($past(fill)) + 3'($past(in_fire)) - 3'($past(out_fire)))
    else $error("request lost or duplicated in pipeline");

  // A stalled middle stage holds its seconds value
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !r2 |=> v2 && $stable(d2))
    else $error("stage 2 data changed while stalled");

  // The clamped inputs can never reach the saturation value
  a_no_saturate: assert property (@(posedge clk) disable iff (rst)
    v2 |-> d2 != 32'hFFFF_FFFF)
    else $error("epoch seconds saturated");

  // Input is refused only when every stage is full
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !date.ready |-> v1 && v2 && epoch.valid && !epoch.ready)
    else $error("input refused with room in pipeline");

endmodule

>>> hw/rtl/cdte_day_count.sv
// Stage 1: clamp the date, count whole days since the epoch and seconds within the day.
module cdte_day_count (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  cdte_pkg::date_t   up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output cdte_pkg::day_sum_t dn_data
);

  logic [11:0]        year_c;
  logic [3:0]         month_c;
  logic [4:0]         day_m1;
  logic [7:0]         year_ofs;
  logic               leap;
  logic               past_skip;
  logic [7:0]         leap_days;
  cdte_pkg::day_sum_t sum;

  // Clamp the year into range
  always_comb begin
    if (up_data.year < cdte_pkg::YearFirst) begin
      year_c = cdte_pkg::YearFirst;
    end else if (up_data.year > cdte_pkg::YearLast) begin
      year_c = cdte_pkg::YearLast;
    end else begin
      year_c = up_data.year;
    end
  end

  assign month_c  = up_data.month;
  assign day_m1   = (up_data.day_of_month == 5'd0) ? 5'd0 : up_data.day_of_month - 5'd1;
  assign year_ofs = 8'(year_c - cdte_pkg::YearFirst);

  // In range, every year divisible by 4 is leap except 2100
  assign leap      = (year_c[1:0] == 2'b00) && (year_c != cdte_pkg::YearSkipLeap);
  assign past_skip = year_c > cdte_pkg::YearSkipLeap;
  // Leap days in whole years 1970 .. year-1
  assign leap_days = 8'((9'(year_ofs) + 9'd1) >> 2) - 8'(past_skip);

  // Day and time-of-day sums
  always_comb begin
    sum.days = 16'(year_ofs) * 16'(cdte_pkg::DaysPerYear)
             + 16'(leap_days)
             + 16'(cdte_pkg::month_offset(month_c))
             + 16'(leap && (month_c > cdte_pkg::MonthFeb))
             + 16'(day_m1);
    sum.tod  = 17'(up_data.hour) * 17'(cdte_pkg::SecsPerHour)
             + 17'(up_data.minute) * 17'(cdte_pkg::SecsPerMinute)
             + 17'(up_data.second);
  end

  // Pipeline register
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= sum;
    end
  end

endmodule

>>> hw/rtl/cdte_sec_scale.sv
// Stage 2: scale days to seconds, add the time of day and saturate to 32 bits.
module cdte_sec_scale (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  cdte_pkg::day_sum_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output cdte_pkg::secs_t    dn_data
);

  logic [32:0]     total;
  cdte_pkg::secs_t secs;

  // Seconds since the epoch, clipped to the 32-bit range
  assign total = 33'(up_data.days) * 33'(cdte_pkg::SecsPerDay) + 33'(up_data.tod);
  assign secs  = total[32] ? 32'hFFFF_FFFF : total[31:0];

  // Pipeline register
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_data <= secs;
    end
  end

endmodule

>>> hw/rtl/cdte_usec_scale.sv
// Stage 3: output register holding seconds and seconds times one million.
module cdte_usec_scale (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  cdte_pkg::secs_t  up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cdte_pkg::secs_t  dn_secs,
  output cdte_pkg::usecs_t dn_usecs
);

  cdte_pkg::usecs_t usecs;

  // 32 x 20 constant multiply; the product fits in 52 bits
  assign usecs = cdte_pkg::usecs_t'(up_data) * cdte_pkg::usecs_t'(cdte_pkg::UsecsPerSec);

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn_secs  <= up_data;
      dn_usecs <= usecs;
    end
  end

endmodule

>>> tb/sv/tb_calendar_date_to_epoch_time.sv
`timescale 1ns / 1ps
// Self-checking regression for the date to epoch converter, with its own predictor.
module tb_calendar_date_to_epoch_time;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomItems  = 1750;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned DirectedRows = 25;

  // Predicted epoch for one request
  typedef struct packed {
    cdte_pkg::secs_t  secs;
    cdte_pkg::usecs_t usecs;
  } epoch_t;

  // One directed request; secs/usecs are used only when typed is set
  typedef struct packed {
    cdte_pkg::date_t  req;
    bit               typed;
    cdte_pkg::secs_t  secs;
    cdte_pkg::usecs_t usecs;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cdte_date_if  date_ch ();
  cdte_epoch_if epoch_ch ();

  calendar_date_to_epoch_time dut (
    .clk   (clk),
    .rst   (rst),
    .date  (date_ch),
    .epoch (epoch_ch)
  );

  epoch_t      pending_epochs [$];
  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        rx_hold       = 1'b0;

  // Days before the first of each month, common year; index 0 acts as January
  int unsigned days_before_month [13] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  row_t directed_rows [DirectedRows] = '{
    // epoch origin, last second in range, and the clamped corners
    '{'{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, 32'd0, 52'd0},
    '{'{12'd2105, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1, 32'd4291747199,
      52'd4291747199000000},
    '{'{12'd0,    4'd1,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, 32'd0, 52'd0},
    '{'{12'd4095, 4'd15, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1, 32'd4291747199,
      52'd4291747199000000},
    // month zero and day zero both land on Jan 1
    '{'{12'd1970, 4'd0,  5'd1,  5'd0,  6'd0,  6'd0},  1'b1, 32'd0, 52'd0},
    '{'{12'd1970, 4'd1,  5'd0,  5'd0,  6'd0,  6'd0},  1'b1, 32'd0, 52'd0},
    // time of day fields past range add linearly
    '{'{12'd1970, 4'd1,  5'd1,  5'd31, 6'd63, 6'd63}, 1'b1, 32'd115443,
      52'd115443000000},
    // leap rules: every fourth year, the 400 rule, and the 2100 exception
    '{'{12'd1972, 4'd2,  5'd29, 5'd12, 6'd0,  6'd0},  1'b0, 32'd0, 52'd0},
    '{'{12'd1972, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 32'd0, 52'd0},
    '{'{12'd2000, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 32'd0, 52'd0},
    '{'{12'd2100, 4'd2,  5'd28, 5'd23, 6'd59, 6'd59}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2100, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 32'd0, 52'd0},
    '{'{12'd2104, 4'd3,  5'd1,  5'd0,  6'd0,  6'd0},  1'b0, 32'd0, 52'd0},
    '{'{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7},  1'b0, 32'd0, 52'd0},
    // February through December in a leap year
    '{'{12'd2024, 4'd2,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd3,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd4,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd5,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd6,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd7,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd8,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd9,  5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd10, 5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd11, 5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0},
    '{'{12'd2024, 4'd12, 5'd15, 5'd10, 6'd30, 6'd45}, 1'b0, 32'd0, 52'd0}
  };

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0d ns  mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Leap years in 1..n
  function automatic longint unsigned leaps_upto(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // Seconds and microseconds since the epoch for one date request
  function automatic epoch_t epoch_of_date(input cdte_pkg::date_t d);
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     dom;
    longint unsigned days;
    longint unsigned total;
    epoch_t          e;
    yr  = d.year;
    if (yr < 1970) yr = 1970;
    if (yr > 2105) yr = 2105;
    mon = (d.month > 12) ? 12 : d.month;
    dom = (d.day_of_month == 0) ? 1 : d.day_of_month;
    days = longint'(dom - 1) + days_before_month[mon];
    if (mon > 2 && (((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0))
      days++;
    days += longint'(365) * (yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969);
    total = days * 86400 + longint'(d.hour) * 3600 + longint'(d.minute) * 60
          + longint'(d.second);
    if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
    e.secs  = total[31:0];
    e.usecs = 52'(total * 1000000);
    return e;
  endfunction

  // Mostly well-formed dates with some bias to leap and range corners;
  // the rest use the full width of every field
  function automatic cdte_pkg::date_t random_date();
    cdte_pkg::date_t d;
    if ($urandom_range(99) < 15) begin
      d.year         = 12'($urandom);
      d.month        = 4'($urandom);
      d.day_of_month = 5'($urandom);
      d.hour         = 5'($urandom);
      d.minute       = 6'($urandom);
      d.second       = 6'($urandom);
    end else begin
      case ($urandom_range(7))
        0: d.year = 12'd1970;
        1: d.year = 12'd2000;
        2: d.year = 12'd2100;
        3: d.year = 12'd2105;
        default: d.year = 12'($urandom_range(2105, 1970));
      endcase
      d.month        = 4'($urandom_range(12, 1));
      d.day_of_month = 5'($urandom_range($urandom_range(1) ? 31 : 28, 1));
      d.hour         = 5'($urandom_range(23));
      d.minute       = 6'($urandom_range(59));
      d.second       = 6'($urandom_range(59));
    end
    return d;
  endfunction

  // Offer one date request, idling first at the current rate; returns at acceptance
  task automatic send_date(input cdte_pkg::date_t d, input epoch_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      date_ch.valid <= 1'b0;
      @(posedge clk);
    end
    date_ch.valid        <= 1'b1;
    date_ch.year         <= d.year;
    date_ch.month        <= d.month;
    date_ch.day_of_month <= d.day_of_month;
    date_ch.hour         <= d.hour;
    date_ch.minute       <= d.minute;
    date_ch.second       <= d.second;
    do @(posedge clk); while (!date_ch.ready);
    pending_epochs.push_back(want);
  endtask

  // Stop offering and wait until every epoch request has come back
  task automatic drain_epochs();
    date_ch.valid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int unsigned count);
    cdte_pkg::date_t d;
    repeat (count) begin
      d = random_date();
      send_date(d, epoch_of_date(d));
    end
  endtask

  // Epoch side: check each accepted request, then pick the next ready
  always @(posedge clk) begin
    epoch_t want;
    if (rst) begin
      epoch_ch.ready <= 1'b0;
    end else begin
      if (epoch_ch.valid && epoch_ch.ready) begin
        if (pending_epochs.size() == 0) begin
          report_mismatch($sformatf("epoch request %0d with no date outstanding",
                                    epoch_ch.epoch_seconds));
        end else begin
          want = pending_epochs.pop_front();
          if (epoch_ch.epoch_seconds !== want.secs)
            report_mismatch($sformatf("epoch_seconds %0d, expected %0d",
                                      epoch_ch.epoch_seconds, want.secs));
          if (epoch_ch.epoch_microseconds !== want.usecs)
            report_mismatch($sformatf("epoch_microseconds %0d, expected %0d",
                                      epoch_ch.epoch_microseconds, want.usecs));
        end
      end
      epoch_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    int unsigned i;
    date_ch.valid        = 1'b0;
    date_ch.year         = '0;
    date_ch.month        = '0;
    date_ch.day_of_month = '0;
    date_ch.hour         = '0;
    date_ch.minute       = '0;
    date_ch.second       = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table, sender sparse and receiver busy
    send_idle_pct = 33;
    recv_idle_pct <= 51;
    for (i = 0; i < DirectedRows; i++) begin
      send_date(directed_rows[i].req,
                directed_rows[i].typed ?
                  epoch_t'{directed_rows[i].secs, directed_rows[i].usecs} :
                  epoch_of_date(directed_rows[i].req));
    end
    drain_epochs();

    send_random(RandomItems / 3);
    drain_epochs();

    // Swap the idle rates
    send_idle_pct = 51;
    recv_idle_pct <= 33;
    send_random(RandomItems / 3);
    drain_epochs();

    // No idling; a long receiver hold-off fills the pipe and backs up the sender
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_random(RandomItems - 2 * (RandomItems / 3));
    drain_epochs();

    // Let any stray epoch request show up before deciding
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/cdte_pkg.sv
hw/rtl/cdte_date_if.sv
hw/rtl/cdte_epoch_if.sv
hw/rtl/cdte_day_count.sv
hw/rtl/cdte_sec_scale.sv
hw/rtl/cdte_usec_scale.sv
hw/rtl/calendar_date_to_epoch_time.sv
tb/sv/tb_calendar_date_to_epoch_time.sv
